/* sv/abem_pkg.sv */
// Shared types, widths and defaults for the audio block edge meter.
`timescale 1ns / 1ps

package abem_pkg;

	// Parameter defaults
	localparam int BLOCK_FRAMES_DEF = 64;
	localparam int COUNT_BITS_DEF   = 24;

	// Field widths
	localparam int SAMPLE_W   = 16;
	localparam int MAG_W      = 16;
	localparam int SQ_W       = 31;
	localparam int SUMSQ_W    = 55;
	localparam int TOTAL_W    = 25;
	localparam int STEP_W     = 16;
	localparam int CHAN_CNT_W = 4;
	localparam int CHAN_POS_W = 3;

	// Channel count limits
	localparam logic [CHAN_CNT_W-1:0] MIN_CHANNELS = 4'd1;
	localparam logic [CHAN_CNT_W-1:0] MAX_CHANNELS = 4'd8;

	// Sum of squares ceiling, 2^54
	localparam logic [SUMSQ_W-1:0] SUMSQ_CAP = {1'b1, {(SUMSQ_W-1){1'b0}}};

	// Register port
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int REG_IDX_LSB = 2;
	localparam logic [0:0] REG_CHANNEL_COUNT = 1'b0;

	// Product stage payload, from the input stage to the accumulator stage
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
		logic [MAG_W-1:0]           mag;
		logic [SQ_W-1:0]            sq;
	} abem_prod_t;

	// One buffer report
	typedef struct packed {
		logic [MAG_W-1:0]   peak_magnitude;
		logic [SUMSQ_W-1:0] sum_of_squares;
		logic [TOTAL_W-1:0] sample_total;
		logic [STEP_W-1:0]  worst_edge_step;
		logic [STEP_W-1:0]  worst_inner_step;
		logic               edge_jump_flag;
	} abem_result_t;

endpackage

/* sv/abem_if.sv */
// Stream interfaces: sample channel and meter result channel.
`timescale 1ns / 1ps

interface abem_sample_if;
	import abem_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface abem_meter_if;
	import abem_pkg::*;

	logic               valid;
	logic               ready;
	logic [MAG_W-1:0]   peak_magnitude;
	logic [SUMSQ_W-1:0] sum_of_squares;
	logic [TOTAL_W-1:0] sample_total;
	logic [STEP_W-1:0]  worst_edge_step;
	logic [STEP_W-1:0]  worst_inner_step;
	logic               edge_jump_flag;

	modport source (output valid, output peak_magnitude, output sum_of_squares,
		output sample_total, output worst_edge_step, output worst_inner_step,
		output edge_jump_flag, input ready);
	modport sink (input valid, input peak_magnitude, input sum_of_squares,
		input sample_total, input worst_edge_step, input worst_inner_step,
		input edge_jump_flag, output ready);
endinterface

/* sv/audio_block_edge_meter_core.sv */
// Top level of the audio block edge meter.
//
//   channel    dir   handshake        payload
//   sample_ch  in    valid/ready      sample, last_sample
//   meter_ch   out   valid/ready      peak, sum of squares, count, edge/inner steps, flag
//   APB        in    psel/penable     channel_count at byte address 0
//
// One sample per clock while sample_ch.ready is high. An accepted sample is
// registered and squared in the input stage, moves into the product register
// and is then folded into the running figures; on a last sample the report is
// loaded into the result register together with that fold.
// Reset is asynchronous and clears all buffer state; channel_count returns to 1.
// sample_ch.ready drops only while a last sample sits in the accumulator stage
// and the previous report has not yet been taken.
`timescale 1ns / 1ps

module audio_block_edge_meter_core #(
	parameter int BLOCK_FRAMES = abem_pkg::BLOCK_FRAMES_DEF,
	parameter int COUNT_BITS   = abem_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [abem_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [abem_pkg::APB_DATA_W-1:0] pwdata,
	output logic [abem_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	abem_sample_if.sink                     sample_ch,
	abem_meter_if.source                    meter_ch
);
	import abem_pkg::*;

	logic [CHAN_CNT_W-1:0] channel_count;
	logic                  advance;
	logic                  prod_valid;
	abem_prod_t            prod;
	logic                  res_valid;
	abem_result_t          res;

	// Configuration
	abem_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.channel_count (channel_count)
	);

	// Input register and squarer
	abem_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample_ch.valid),
		.in_sample  (sample_ch.sample),
		.in_last    (sample_ch.last_sample),
		.advance    (advance),
		.prod_valid (prod_valid),
		.prod       (prod)
	);

	// Running figures and report
	abem_accum #(
		.BLOCK_FRAMES (BLOCK_FRAMES),
		.COUNT_BITS   (COUNT_BITS)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.prod_valid    (prod_valid),
		.prod          (prod),
		.channel_count (channel_count),
		.res_ready     (meter_ch.ready),
		.advance       (advance),
		.res_valid     (res_valid),
		.res           (res)
	);

	assign sample_ch.ready = advance;

	assign meter_ch.valid            = res_valid;
	assign meter_ch.peak_magnitude   = res.peak_magnitude;
	assign meter_ch.sum_of_squares   = res.sum_of_squares;
	assign meter_ch.sample_total     = res.sample_total;
	assign meter_ch.worst_edge_step  = res.worst_edge_step;
	assign meter_ch.worst_inner_step = res.worst_inner_step;
	assign meter_ch.edge_jump_flag   = res.edge_jump_flag;

endmodule

/* sv/abem_regs.sv */
// Configuration register file: channel count behind an APB-style port.
`timescale 1ns / 1ps

module abem_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [abem_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [abem_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [abem_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic [abem_pkg::CHAN_CNT_W-1:0]     channel_count
);
	import abem_pkg::*;

	logic [0:0]            reg_idx;
	logic                  wr_en;
	logic [CHAN_CNT_W-1:0] chan_cnt_q;

	assign reg_idx = paddr[REG_IDX_LSB +: 1];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	// Register write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= MIN_CHANNELS;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CHANNEL_COUNT: chan_cnt_q <= pwdata[CHAN_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			REG_CHANNEL_COUNT: prdata = APB_DATA_W'(chan_cnt_q);
			default:           prdata = '0;
		endcase
	end

	assign channel_count = chan_cnt_q;

endmodule

/* sv/abem_front.sv */
// Input stage: sample register, magnitude and square.
`timescale 1ns / 1ps

module abem_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [abem_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                in_last,
	input  logic                                advance,
	output logic                                prod_valid,
	output abem_pkg::abem_prod_t                prod
);
	import abem_pkg::*;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       last_s1;
	logic [MAG_W-1:0]           mag;
	logic [2*MAG_W-1:0]         sq_full;

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			sample_s1 <= in_sample;
			last_s1   <= in_last;
		end
	end

	// |x| fits 16 bits unsigned, including -32768
	assign mag     = sample_s1[SAMPLE_W-1] ? MAG_W'(~sample_s1 + 1'b1) : MAG_W'(sample_s1);
	assign sq_full = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};

	assign prod_valid  = valid_s1;
	assign prod.sample = sample_s1;
	assign prod.last   = last_s1;
	assign prod.mag    = mag;
	assign prod.sq     = sq_full[SQ_W-1:0];

endmodule

/* sv/abem_accum.sv */
// Accumulator stage: running figures, frame counters and the result register.
`timescale 1ns / 1ps

module abem_accum #(
	parameter int BLOCK_FRAMES = abem_pkg::BLOCK_FRAMES_DEF,
	parameter int COUNT_BITS   = abem_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            prod_valid,
	input  abem_pkg::abem_prod_t            prod,
	input  logic [abem_pkg::CHAN_CNT_W-1:0] channel_count,
	input  logic                            res_ready,
	output logic                            advance,
	output logic                            res_valid,
	output abem_pkg::abem_result_t          res
);
	import abem_pkg::*;

	localparam int FRAME_W = $clog2(BLOCK_FRAMES);
	localparam int CNT_W   = COUNT_BITS + 1;

	// Product register
	logic       valid_s2;
	abem_prod_t prod_s2;

	// Running state
	logic signed [SAMPLE_W-1:0] prev_q;
	logic                       first_q;
	logic [CHAN_POS_W-1:0]      chan_pos_q;
	logic [FRAME_W-1:0]         frame_pos_q;
	logic [MAG_W-1:0]           peak_q;
	logic [SUMSQ_W-1:0]         sumsq_q;
	logic [CNT_W-1:0]           count_q;
	logic [STEP_W-1:0]          edge_q;
	logic [STEP_W-1:0]          inner_q;

	// Next values
	logic [MAG_W-1:0]      peak_nx;
	logic [SUMSQ_W:0]      sum_ext;
	logic [SUMSQ_W-1:0]    sumsq_nx;
	logic [CNT_W-1:0]      count_nx;
	logic [SAMPLE_W:0]     diff;
	logic [SAMPLE_W:0]     diff_abs;
	logic [STEP_W-1:0]     step;
	logic [STEP_W-1:0]     edge_nx;
	logic [STEP_W-1:0]     inner_nx;
	logic [CHAN_CNT_W-1:0] chans;
	logic                  frame_done;
	logic                  block_done;
	logic [CHAN_POS_W-1:0] chan_pos_nx;
	logic [FRAME_W-1:0]    frame_pos_nx;
	logic [TOTAL_W-1:0]    total_nx;

	logic         hold;
	logic         retire;
	logic         res_valid_q;
	abem_result_t res_q;

	// A last item waits while the previous report is still unread
	assign hold    = valid_s2 & prod_s2.last & res_valid_q & ~res_ready;
	assign advance = ~hold;
	assign retire  = valid_s2 & ~hold;

	// Product register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= prod_valid;
		end
	end

	// Product register payload
	always_ff @(posedge clk) begin
		if (advance && prod_valid) begin
			prod_s2 <= prod;
		end
	end

	// Peak and saturating sum of squares
	assign peak_nx  = (prod_s2.mag > peak_q) ? prod_s2.mag : peak_q;
	assign sum_ext  = {1'b0, sumsq_q} + (SUMSQ_W+1)'(prod_s2.sq);
	assign sumsq_nx = (sum_ext >= {1'b0, SUMSQ_CAP}) ? SUMSQ_CAP : sum_ext[SUMSQ_W-1:0];

	// Sample count stops at 2^COUNT_BITS
	assign count_nx = count_q[COUNT_BITS] ? count_q : count_q + CNT_W'(1);

	// Step from the previous sample, split by frame position
	assign diff     = {prod_s2.sample[SAMPLE_W-1], prod_s2.sample} - {prev_q[SAMPLE_W-1], prev_q};
	assign diff_abs = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
	assign step     = diff_abs[STEP_W-1:0];

	always_comb begin
		edge_nx  = edge_q;
		inner_nx = inner_q;
		if (!first_q) begin
			if (frame_pos_q == '0) begin
				if (step > edge_q) edge_nx = step;
			end else begin
				if (step > inner_q) inner_nx = step;
			end
		end
	end

	// Channel and block-frame counters
	always_comb begin
		priority if (channel_count == '0) begin
			chans = MIN_CHANNELS;
		end else if (channel_count > MAX_CHANNELS) begin
			chans = MAX_CHANNELS;
		end else begin
			chans = channel_count;
		end
	end

	assign frame_done = ({1'b0, chan_pos_q} + CHAN_CNT_W'(1)) >= chans;
	assign block_done = ({1'b0, frame_pos_q} + (FRAME_W+1)'(1)) >= (FRAME_W+1)'(BLOCK_FRAMES);

	always_comb begin
		chan_pos_nx  = chan_pos_q + 1'b1;
		frame_pos_nx = frame_pos_q;
		if (frame_done) begin
			chan_pos_nx  = '0;
			frame_pos_nx = block_done ? '0 : frame_pos_q + 1'b1;
		end
	end

	// Count to report width: zero-extend or drop high bits
	for (genvar i = 0; i < TOTAL_W; i++) begin : g_total
		if (i < CNT_W) begin : g_bit
			assign total_nx[i] = count_nx[i];
		end else begin : g_zero
			assign total_nx[i] = 1'b0;
		end
	end

	// State update; a last item clears everything after reporting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			first_q     <= 1'b1;
			chan_pos_q  <= '0;
			frame_pos_q <= '0;
			peak_q      <= '0;
			sumsq_q     <= '0;
			count_q     <= '0;
			edge_q      <= '0;
			inner_q     <= '0;
		end else if (retire) begin
			if (prod_s2.last) begin
				prev_q      <= '0;
				first_q     <= 1'b1;
				chan_pos_q  <= '0;
				frame_pos_q <= '0;
				peak_q      <= '0;
				sumsq_q     <= '0;
				count_q     <= '0;
				edge_q      <= '0;
				inner_q     <= '0;
			end else begin
				prev_q      <= prod_s2.sample;
				first_q     <= 1'b0;
				chan_pos_q  <= chan_pos_nx;
				frame_pos_q <= frame_pos_nx;
				peak_q      <= peak_nx;
				sumsq_q     <= sumsq_nx;
				count_q     <= count_nx;
				edge_q      <= edge_nx;
				inner_q     <= inner_nx;
			end
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (retire && prod_s2.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (retire && prod_s2.last) begin
			res_q.peak_magnitude   <= peak_nx;
			res_q.sum_of_squares   <= sumsq_nx;
			res_q.sample_total     <= total_nx;
			res_q.worst_edge_step  <= edge_nx;
			res_q.worst_inner_step <= inner_nx;
			res_q.edge_jump_flag   <= edge_nx > inner_nx;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* sv/abem_checker.sv */
// Port-level checks for the edge meter, bound to the top level.
`timescale 1ns / 1ps

module abem_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            pready,
	input logic                            m_valid,
	input logic                            m_ready,
	input logic [abem_pkg::MAG_W-1:0]      m_peak,
	input logic [abem_pkg::SUMSQ_W-1:0]    m_sumsq,
	input logic [abem_pkg::TOTAL_W-1:0]    m_total,
	input logic [abem_pkg::STEP_W-1:0]     m_edge,
	input logic [abem_pkg::STEP_W-1:0]     m_inner,
	input logic                            m_flag
);
	import abem_pkg::*;

	localparam logic [MAG_W-1:0] PEAK_MAX = {1'b1, {(MAG_W-1){1'b0}}};

	// A report not taken stays put
	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid && !m_ready |=> m_valid && $stable(m_peak) && $stable(m_sumsq)
			&& $stable(m_total) && $stable(m_edge) && $stable(m_inner) && $stable(m_flag))
		else $error("meter report changed while stalled");

	// Flag agrees with the two step figures
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid |-> (m_flag == (m_edge > m_inner)))
		else $error("edge_jump_flag disagrees with step figures");

	// Peak and energy never exceed their ceilings
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid |-> (m_peak <= PEAK_MAX) && (m_sumsq <= SUMSQ_CAP))
		else $error("meter figure beyond its ceiling");

	// Register port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind audio_block_edge_meter_core abem_checker u_abem_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.pready  (pready),
	.m_valid (meter_ch.valid),
	.m_ready (meter_ch.ready),
	.m_peak  (meter_ch.peak_magnitude),
	.m_sumsq (meter_ch.sum_of_squares),
	.m_total (meter_ch.sample_total),
	.m_edge  (meter_ch.worst_edge_step),
	.m_inner (meter_ch.worst_inner_step),
	.m_flag  (meter_ch.edge_jump_flag)
);

/* bench/abem_meter_checker.sv */
// Checker for the audio block edge meter: tracks transfers, predicts reports, compares them.
`timescale 1ns / 1ps

module abem_meter_checker #(
	parameter int BLOCK_FRAMES = abem_pkg::BLOCK_FRAMES_DEF,
	parameter int COUNT_BITS   = abem_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [abem_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [abem_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [abem_pkg::APB_DATA_W-1:0] prdata,
	abem_sample_if                          smp_ch,
	abem_meter_if                           mtr_ch,
	output int unsigned                     mismatches,
	output int unsigned                     reports_open,
	output int unsigned                     reports_seen
);
	import abem_pkg::*;

	localparam longint unsigned SQUARE_CEIL = 64'd1 << (SUMSQ_W - 1);
	localparam longint unsigned COUNT_CEIL  = 64'd1 << COUNT_BITS;

	int unsigned fail_cnt = 0;
	int unsigned seen_cnt = 0;

	// Register copy and running buffer figures
	logic [CHAN_CNT_W-1:0] chan_setting;
	int                    prior_sample;
	bit                    awaiting_first;
	int                    lane_pos;
	int                    frame_pos;
	int                    peak_mag;
	longint unsigned       square_sum;
	longint unsigned       sample_cnt;
	int                    edge_step_max;
	int                    inner_step_max;

	// Reports owed by the block, oldest first
	abem_result_t pending_reports[$];

	assign mismatches   = fail_cnt;
	assign reports_seen = seen_cnt;

	task automatic clear_buffer();
		prior_sample   = 0;
		awaiting_first = 1'b1;
		lane_pos       = 0;
		frame_pos      = 0;
		peak_mag       = 0;
		square_sum     = 0;
		sample_cnt     = 0;
		edge_step_max  = 0;
		inner_step_max = 0;
	endtask

	task automatic check_field(input string fname, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			fail_cnt++;
		end
	endtask

	// Fold one sample into the buffer figures; a last sample closes out a report
	task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
		int              v;
		int              mag;
		int              step;
		int              lanes;
		longint unsigned sq;
		abem_result_t    rep;
		v     = smp;
		mag   = (v < 0) ? -v : v;
		sq    = longint'(mag) * longint'(mag);
		lanes = (chan_setting == 0) ? 1 : (chan_setting > 8) ? 8 : int'(chan_setting);

		if (mag > peak_mag)
			peak_mag = mag;
		if (square_sum >= SQUARE_CEIL || sq >= SQUARE_CEIL - square_sum)
			square_sum = SQUARE_CEIL;
		else
			square_sum += sq;
		if (sample_cnt < COUNT_CEIL)
			sample_cnt++;

		// step against the previous sample, sorted by frame position
		if (!awaiting_first) begin
			step = v - prior_sample;
			if (step < 0)
				step = -step;
			if (frame_pos == 0) begin
				if (step > edge_step_max)
					edge_step_max = step;
			end else if (step > inner_step_max) begin
				inner_step_max = step;
			end
		end
		awaiting_first = 1'b0;
		prior_sample   = v;

		// channel and block-frame counters
		if (lane_pos + 1 >= lanes) begin
			lane_pos  = 0;
			frame_pos = (frame_pos + 1 >= BLOCK_FRAMES) ? 0 : frame_pos + 1;
		end else begin
			lane_pos++;
		end

		if (lst) begin
			rep.peak_magnitude   = MAG_W'(peak_mag);
			rep.sum_of_squares   = SUMSQ_W'(square_sum);
			rep.sample_total     = TOTAL_W'(sample_cnt);
			rep.worst_edge_step  = STEP_W'(edge_step_max);
			rep.worst_inner_step = STEP_W'(inner_step_max);
			rep.edge_jump_flag   = (edge_step_max > inner_step_max);
			pending_reports.push_back(rep);
			clear_buffer();
		end
	endtask

	// Watch the register port and both channels
	always @(posedge clk or negedge arst_n) begin
		abem_result_t want;
		if (!arst_n) begin
			chan_setting = MIN_CHANNELS;
			clear_buffer();
			pending_reports.delete();
		end else begin
			// report transfer against the oldest prediction
			if (mtr_ch.valid && mtr_ch.ready) begin
				seen_cnt++;
				if (pending_reports.size() == 0) begin
					$error("meter report transfer with no buffer closed");
					fail_cnt++;
				end else begin
					want = pending_reports.pop_front();
					check_field("peak_magnitude", want.peak_magnitude, mtr_ch.peak_magnitude);
					check_field("sum_of_squares", want.sum_of_squares, mtr_ch.sum_of_squares);
					check_field("sample_total", want.sample_total, mtr_ch.sample_total);
					check_field("worst_edge_step", want.worst_edge_step, mtr_ch.worst_edge_step);
					check_field("worst_inner_step", want.worst_inner_step,
						mtr_ch.worst_inner_step);
					check_field("edge_jump_flag", want.edge_jump_flag, mtr_ch.edge_jump_flag);
				end
			end

			// register access phase; unmapped writes are dropped
			if (psel && penable && pready
				&& paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_CHANNEL_COUNT) begin
				if (pwrite)
					chan_setting = pwdata[CHAN_CNT_W-1:0];
				else
					check_field("channel_count", {28'd0, chan_setting}, prdata);
			end

			if (smp_ch.valid && smp_ch.ready)
				accumulate_sample(smp_ch.sample, smp_ch.last_sample);
		end
		reports_open <= pending_reports.size();
	end

endmodule

/* bench/tb_audio_block_edge_meter_core.sv */
// Testbench top for the audio block edge meter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_audio_block_edge_meter_core;
	import abem_pkg::*;

	localparam int BLOCK_FRAMES = BLOCK_FRAMES_DEF;
	localparam int COUNT_BITS   = COUNT_BITS_DEF;
	localparam int CLK_PERIOD   = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES  = 400;
	localparam int N_SEGS       = 12;
	localparam int SEG_ITEMS    = 130;
	localparam int SEG_BUFS     = 4;
	localparam int PRESSURE_SEG = 9;

	localparam logic [APB_ADDR_W-1:0] ADDR_CHANNEL_COUNT = {REG_CHANNEL_COUNT, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED      = 3'd4;
	localparam bit                    APB_RD             = 1'b0;
	localparam bit                    APB_WR             = 1'b1;

	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'h8000;
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'h7fff;

	// channel setting per segment: extremes, out-of-range values, ordinary counts
	localparam logic [CHAN_CNT_W-1:0] CHAN_PLAN [N_SEGS] = '{
		4'd1, 4'd8, 4'd2, 4'd0, 4'd3, 4'd15, 4'd5, 4'd7, 4'd8, 4'd4, 4'd9, 4'd1
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned mismatches;
	int unsigned reports_open;
	int unsigned reports_seen;

	int unsigned items_sent    = 0;
	int unsigned buffers_sent  = 0;
	int unsigned cycle_cnt     = 0;
	int          send_idle_pct = 31;
	int          recv_idle_pct = 56;
	int          holds_asked   = 0;

	abem_sample_if smp_ch ();
	abem_meter_if  mtr_ch ();

	audio_block_edge_meter_core #(
		.BLOCK_FRAMES(BLOCK_FRAMES),
		.COUNT_BITS  (COUNT_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.sample_ch(smp_ch),
		.meter_ch (mtr_ch)
	);

	abem_meter_checker #(
		.BLOCK_FRAMES(BLOCK_FRAMES),
		.COUNT_BITS  (COUNT_BITS)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.smp_ch      (smp_ch),
		.mtr_ch      (mtr_ch),
		.mismatches  (mismatches),
		.reports_open(reports_open),
		.reports_seen(reports_seen)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Report side: random stalls, plus a long hold-off whenever one is requested
	initial begin : report_sink
		int hold_left;
		int holds_taken;
		hold_left    = 0;
		holds_taken  = 0;
		mtr_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				mtr_ch.ready <= 1'b0;
				hold_left--;
			end else if (holds_taken != holds_asked) begin
				holds_taken++;
				hold_left = HOLD_CYCLES - 1;
				mtr_ch.ready <= 1'b0;
			end else begin
				mtr_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// One sample transfer, with random idle cycles ahead of it
	task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input bit lst);
		while ($urandom_range(99) < send_idle_pct) begin
			smp_ch.valid <= 1'b0;
			@(posedge clk);
		end
		smp_ch.valid       <= 1'b1;
		smp_ch.sample      <= smp;
		smp_ch.last_sample <= lst;
		@(posedge clk);
		while (!smp_ch.ready)
			@(posedge clk);
		items_sent++;
		if (lst)
			buffers_sent++;
	endtask

	// Setup and access cycle on the register port, then psel and penable drop
	task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering samples and let every owed report come out
	task automatic quiesce();
		smp_ch.valid <= 1'b0;
		@(posedge clk);
		while (reports_open != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_channels(input logic [CHAN_CNT_W-1:0] n);
		quiesce();
		apb_access(APB_WR, ADDR_CHANNEL_COUNT, {28'd0, n});
		apb_access(APB_RD, ADDR_CHANNEL_COUNT, '0);
	endtask

	// Mostly full-range values; smooth buffers drift in small steps with rare spikes
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(
		input logic signed [SAMPLE_W-1:0] prior, input bit smooth);
		int roll;
		int v;
		roll = $urandom_range(99);
		if (roll < 8) begin
			case ($urandom_range(3))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				default: v = -1;
			endcase
		end else if (smooth && roll < 96) begin
			v = int'(prior) + int'($urandom_range(128)) - 64;
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
		end else begin
			v = int'($urandom_range(65535)) - 32768;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	initial begin : stimulus
		int                          seg;
		int                          i;
		int                          roll;
		int                          lanes;
		int                          buf_left;
		int                          seg_items;
		int                          seg_bufs;
		bit                          smooth;
		logic signed [SAMPLE_W-1:0]  smp;
		logic signed [SAMPLE_W-1:0]  prev_smp;

		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		smp_ch.valid       = 1'b0;
		smp_ch.sample      = '0;
		smp_ch.last_sample = 1'b0;
		buf_left           = 0;
		smooth             = 1'b0;
		prev_smp           = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the channel register
		apb_access(APB_RD, ADDR_CHANNEL_COUNT, '0);

		// single-sample buffer at the negative extreme: no step measured
		send_item(SMP_MIN, 1'b1);
		// full-scale swings, mono: only inner steps
		send_item(SMP_MAX, 1'b0);
		send_item(SMP_MIN, 1'b0);
		send_item(16'sd0, 1'b1);

		// four channels: frame zero holds edge steps after its first sample
		program_channels(4'd4);
		send_item(SMP_MAX, 1'b0);
		send_item(SMP_MIN, 1'b0);
		send_item(SMP_MAX, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(16'sd5, 1'b1);

		// channel count lowered mid-buffer with the lane position past the new count
		send_item(16'sd100, 1'b0);
		send_item(-16'sd100, 1'b0);
		send_item(16'sd200, 1'b0);
		program_channels(4'd2);
		send_item(-16'sd200, 1'b0);
		send_item(16'sd300, 1'b0);
		send_item(-16'sd300, 1'b1);

		// zero channels acts as one
		program_channels(4'd0);
		send_item(-16'sd1, 1'b0);
		send_item(16'sd0, 1'b1);

		// fifteen acts as eight; a write to an unmapped address changes nothing
		program_channels(4'd15);
		apb_access(APB_WR, ADDR_UNMAPPED, 32'd3);
		apb_access(APB_RD, ADDR_CHANNEL_COUNT, '0);
		for (i = 0; i < 9; i++)
			send_item(i[0] ? SMP_MIN + SAMPLE_W'(i) : SAMPLE_W'(i * 1500), i == 8);

		// random buffers over the channel plan; a buffer may straddle a segment
		for (seg = 0; seg < N_SEGS; seg++) begin
			program_channels(CHAN_PLAN[seg]);
			send_idle_pct = (seg < 4) ? 31 : (seg < 8) ? 56 : 0;
			recv_idle_pct = (seg < 4) ? 56 : (seg < 8) ? 31 : 0;
			if (seg == PRESSURE_SEG)
				holds_asked++;
			lanes = (CHAN_PLAN[seg] == 0) ? 1 : (CHAN_PLAN[seg] > 8) ? 8 : int'(CHAN_PLAN[seg]);
			seg_items = 0;
			seg_bufs  = 0;
			while (seg_items < SEG_ITEMS || seg_bufs < SEG_BUFS
				|| (seg == N_SEGS - 1 && buf_left != 0)) begin
				if (buf_left == 0) begin
					roll   = $urandom_range(99);
					smooth = 1'($urandom_range(1));
					if (seg == PRESSURE_SEG)
						buf_left = $urandom_range(3, 1);
					else if (roll < 74)
						buf_left = $urandom_range(24, 1);
					else if (roll < 94)
						buf_left = $urandom_range(200, 25);
					else
						buf_left = lanes * BLOCK_FRAMES + $urandom_range(80, 1);
				end
				smp = pick_sample(prev_smp, smooth);
				buf_left--;
				send_item(smp, buf_left == 0);
				prev_smp = smp;
				seg_items++;
				if (buf_left == 0)
					seg_bufs++;
			end
		end

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d samples in %0d buffers, %0d meter reports compared",
			items_sent, buffers_sent, reports_seen);
		$display("Summary: %0d channel settings, both idle orders, one long report hold-off",
			N_SEGS + 4);
		if (mismatches == 0 && reports_open == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
